FILE: hw/rtl/plx_pkg.sv
package plx_pkg;

  // Widths of the frame statistics accumulators.
  localparam int unsigned SUM_W = 25;
  localparam int unsigned CNT_W = 17;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Default sampling stride of the statistics.
  localparam int unsigned SAMPLE_STRIDE_DEF = 7;

  // Configuration register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_PIXEL_FORMAT = 1'b0;

  // Pixel format codes.
  localparam logic [1:0] FMT_GREY      = 2'd0;
  localparam logic [1:0] FMT_YUYV      = 2'd1;
  localparam logic [1:0] FMT_RGB565    = 2'd2;
  localparam logic [1:0] FMT_RGB565X   = 2'd3;
  localparam logic [1:0] FMT_RESET     = FMT_RGB565;

  // Luma weights, scaled by 256.
  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd151;
  localparam logic [7:0] COEF_B = 8'd28;

  typedef enum logic [1:0] {
    CH_R,
    CH_G,
    CH_B
  } chan_e;

  function automatic logic [7:0] luma_coef(chan_e ch);
    logic [7:0] c;
    case (ch)
      CH_R:    c = COEF_R;
      CH_G:    c = COEF_G;
      CH_B:    c = COEF_B;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/plx_luma.sv
module plx_luma (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] word_i,
  output logic        done_o,
  output logic [7:0]  luma_o
);
  import plx_pkg::*;

  logic        busy_q;
  logic        done_q;
  chan_e       step_q;
  logic [15:0] word_q;
  logic [15:0] acc_q;
  logic [7:0]  chan;
  logic [15:0] prod;

  // One channel is expanded to eight bits and weighted per cycle.
  always_comb begin
    case (step_q)
      CH_R:    chan = {word_q[15:11], 3'b000};
      CH_G:    chan = {word_q[10:5], 2'b00};
      CH_B:    chan = {word_q[4:0], 3'b000};
      default: chan = '0;
    endcase
  end

  assign prod = luma_coef(step_q) * chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= CH_R;
    end else begin
      done_q <= !start_i && busy_q && (step_q == CH_B);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= CH_R;
        word_q <= word_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_q + prod;
        if (step_q == CH_B) begin
          busy_q <= 1'b0;
          step_q <= CH_R;
        end else begin
          step_q <= chan_e'(step_q + 2'd1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign luma_o = acc_q[15:8];

endmodule

FILE: hw/rtl/plx_div.sv
module plx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plx_pkg::SUM_W-1:0] dividend_i,
  input  logic [plx_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [plx_pkg::SUM_W-1:0] quotient_o
);
  import plx_pkg::*;

  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (iter_q == ITER_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(SUM_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q  <= {quo_q[SUM_W-2:0], ge};
        rem_q  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        iter_q <= iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/pixel_luma_extract_with_stats.sv
// Pixel luma extractor with per-frame statistics. Each accepted word carries one 16-bit camera
// pixel and yields one result word with its 8-bit luma. The pixel_format register (byte address
// 0, reset value RGB565) selects the conversion: grey and YUYV pass the low byte through, RGB565
// expands 5/6/5 to eight bits per channel and forms (77*R + 151*G + 28*B) >> 8, and the
// byte-swapped RGB565 variant exchanges the two bytes first. Every SAMPLE_STRIDE-th pixel of a
// frame, starting with the first one, updates a running minimum, maximum and saturating sum. The
// word marked as the last pixel of the frame also reports the minimum, the maximum and the
// truncated mean, after which the statistics restart; on all other words these fields are zero.
// The block works on one pixel at a time and holds in_stall_o high while busy. An RGB565 pixel
// takes longer than a grey or YUYV pixel, because the three channel products go through one
// shared 8x8 multiply-accumulate unit, one channel per cycle. On the last pixel of a frame the
// mean is formed by a radix-2 divider, one quotient bit per cycle. A finished result sits in the
// output register, so a new pixel can be taken while the previous word still waits on
// out_stall_i. Configuration must be written only while idle; the block does not enforce it.
module pixel_luma_extract_with_stats #(
  parameter int unsigned SAMPLE_STRIDE = plx_pkg::SAMPLE_STRIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plx_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 pixel_word_i,
  input  logic                        last_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  luma_o,
  output logic                        frame_done_o,
  output logic [7:0]                  frame_min_o,
  output logic [7:0]                  frame_max_o,
  output logic [7:0]                  frame_mean_o
);
  import plx_pkg::*;

  localparam int unsigned          PHASE_W    = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam logic [PHASE_W-1:0]   PHASE_LAST = PHASE_W'(SAMPLE_STRIDE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LUMA,
    S_STATS,
    S_DIV_GO,
    S_DIV,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [1:0]       fmt_q;
  logic             last_q;
  logic [7:0]       luma_q;
  logic [PHASE_W-1:0] phase_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] count_q;
  logic [7:0]       min_q;
  logic [7:0]       max_q;
  logic [7:0]       res_min_q;
  logic [7:0]       res_max_q;
  logic [7:0]       res_mean_q;

  logic             out_valid_q;
  logic [7:0]       out_luma_q;
  logic             out_done_q;
  logic [7:0]       out_min_q;
  logic [7:0]       out_max_q;
  logic [7:0]       out_mean_q;

  logic             in_acc;
  logic             cfg_wr;
  logic [15:0]      word_sw;
  logic             luma_start;
  logic             luma_done;
  logic [7:0]       luma_res;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [SUM_W:0]   sum_ext;
  logic [7:0]       mean_clamp;

  // The configuration port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PIXEL_FORMAT);
  assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? {30'd0, fmt_q} : 32'd0;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // The byte-swapped format is turned into plain RGB565 before the multiply-accumulate unit.
  assign word_sw    = (fmt_q == FMT_RGB565X) ? {pixel_word_i[7:0], pixel_word_i[15:8]}
                                             : pixel_word_i;
  assign luma_start = in_acc && ((fmt_q == FMT_RGB565) || (fmt_q == FMT_RGB565X));

  plx_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (luma_start),
    .word_i  (word_sw),
    .done_o  (luma_done),
    .luma_o  (luma_res)
  );

  assign div_start = (state_q == S_DIV_GO);

  plx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // A mean above 255 can only follow saturation of the sum or count and is clamped.
  assign mean_clamp = (div_quo[SUM_W-1:8] != '0) ? 8'hFF : div_quo[7:0];
  assign sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(luma_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= FMT_RESET;
      phase_q     <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      min_q       <= 8'hFF;
      max_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fmt_q <= pwdata[1:0];
      end
      // In the emit state the output register is handled by the emit branch below.
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q <= last_pixel_i;
            luma_q <= pixel_word_i[7:0];
            state_q <= luma_start ? S_LUMA : S_STATS;
          end
        end
        S_LUMA: begin
          if (luma_done) begin
            luma_q  <= luma_res;
            state_q <= S_STATS;
          end
        end
        S_STATS: begin
          if (phase_q == '0) begin
            sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            if (count_q != COUNT_MAX) begin
              count_q <= count_q + CNT_W'(1);
            end
            if (luma_q < min_q) begin
              min_q <= luma_q;
            end
            if (luma_q > max_q) begin
              max_q <= luma_q;
            end
          end
          phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);
          res_min_q  <= 8'h00;
          res_max_q  <= 8'h00;
          res_mean_q <= 8'h00;
          state_q    <= last_q ? S_DIV_GO : S_EMIT;
        end
        S_DIV_GO: begin
          // The divider takes the totals on this edge; the statistics restart for the next frame.
          res_min_q <= min_q;
          res_max_q <= max_q;
          phase_q   <= '0;
          sum_q     <= '0;
          count_q   <= '0;
          min_q     <= 8'hFF;
          max_q     <= 8'h00;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_mean_q <= mean_clamp;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_luma_q  <= luma_q;
            out_done_q  <= last_q;
            out_min_q   <= res_min_q;
            out_max_q   <= res_max_q;
            out_mean_q  <= res_mean_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign luma_o       = out_luma_q;
  assign frame_done_o = out_done_q;
  assign frame_min_o  = out_min_q;
  assign frame_max_o  = out_max_q;
  assign frame_mean_o = out_mean_q;

  // An accepted word keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o)
    else $error("block ready right after accepting a word");

  // A new result word only appears when leaving the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result word appeared outside the emit state");

  // Statistics fields are zero on words that do not close a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_done_o) |->
      (frame_min_o == 8'h00) && (frame_max_o == 8'h00) && (frame_mean_o == 8'h00))
    else $error("statistics reported on a word that does not end a frame");

  // The divider reports completion only while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
